// ===== rtl/core/smo_pkg.sv =====
// shared types and constants of the selection mask outline block
// no dependencies
`timescale 1ns / 1ps

package smo_pkg;

   localparam int CSR_DATA_W   = 11;
   localparam int CSR_INDEX_W  = 1;
   localparam int PIX_W        = 10;
   localparam int RESET_WIDTH  = 800;
   localparam int RESET_HEIGHT = 600;
   localparam int MIN_SIZE     = 3;

   // window: bit 4 is the centre pixel, the rest are its neighbours
   localparam logic [8:0] NEIGHBOUR_MASK = 9'h1EF;
   localparam int         CENTRE_BIT     = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // position flags of one item, passed from the counters to the window stage
   typedef struct packed {
      logic res_valid;
      logic inner;
   } pos_flags_type;

   // line store entry: previous row in bit 1, row before that in bit 0
   typedef struct packed {
      logic mid;
      logic up;
   } line_entry_type;

endpackage

// ===== rtl/core/smo_line_mem.sv =====
// two-row line store: one synchronous memory with a registered read
// clears itself after reset; depends on smo_pkg
`timescale 1ns / 1ps

module smo_line_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output smo_pkg::line_entry_type      rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  smo_pkg::line_entry_type      wr_data,
   output logic                         busy
);
   import smo_pkg::*;

   localparam int AW = $clog2(DEPTH);

   line_entry_type mem [DEPTH];
   line_entry_type rd_data_ff;
   logic           clr_busy_ff;
   logic           clr_busy_in;
   logic [AW-1:0]  clr_addr_ff;
   logic [AW-1:0]  clr_addr_in;
   logic           we;
   logic [AW-1:0]  wa;
   line_entry_type wd;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign we = clr_busy_ff || wr_en;
   assign wa = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign wd = clr_busy_ff ? line_entry_type'('0) : wr_data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

// ===== rtl/core/smo_position.sv =====
// frame size registers and raster position counters
// depends on smo_pkg
`timescale 1ns / 1ps

module smo_position #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  smo_pkg::csr_index_type              csr_index,
   input  logic [smo_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                accept,
   input  logic                                frame_start,
   output logic [$clog2(MAX_WIDTH)-1:0]        pos_x,
   output logic [$clog2(MAX_HEIGHT)-1:0]       pos_y,
   output smo_pkg::pos_flags_type              pos_flags
);
   import smo_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WW   = CW + 1;
   localparam int HW   = RW + 1;
   localparam int SWW  = (WW > CSR_DATA_W) ? WW : CSR_DATA_W;
   localparam int SHW  = (HW > CSR_DATA_W) ? HW : CSR_DATA_W;
   localparam int W_RESET = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int H_RESET = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

   logic [WW-1:0]  width_ff;
   logic [WW-1:0]  width_in;
   logic [HW-1:0]  height_ff;
   logic [HW-1:0]  height_in;
   logic [CW-1:0]  col_ff;
   logic [CW-1:0]  col_in;
   logic [RW-1:0]  row_ff;
   logic [RW-1:0]  row_in;
   logic [SWW-1:0] wr_w;
   logic [SHW-1:0] wr_h;
   logic [CW-1:0]  c0;
   logic [RW-1:0]  r0;
   logic [HW-1:0]  r1;
   logic [CW-1:0]  x;
   logic [RW-1:0]  y;
   logic [WW-1:0]  x_next;
   logic [HW-1:0]  y_next;

   // clamped size registers
   always_comb begin
      wr_w      = SWW'(csr_write_data);
      wr_h      = SHW'(csr_write_data);
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               if (wr_w < SWW'(MIN_SIZE)) begin
                  width_in = WW'(MIN_SIZE);
               end else if (wr_w > SWW'(MAX_WIDTH)) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(wr_w);
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (wr_h < SHW'(MIN_SIZE)) begin
                  height_in = HW'(MIN_SIZE);
               end else if (wr_h > SHW'(MAX_HEIGHT)) begin
                  height_in = HW'(MAX_HEIGHT);
               end else begin
                  height_in = HW'(wr_h);
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // position of the incoming item, wrapped against the size in use
   always_comb begin
      c0 = frame_start ? '0 : col_ff;
      r0 = frame_start ? '0 : row_ff;
      if ({1'b0, c0} >= width_ff) begin
         x  = '0;
         r1 = {1'b0, r0} + 1'b1;
      end else begin
         x  = c0;
         r1 = {1'b0, r0};
      end
      y = (r1 >= height_ff) ? '0 : RW'(r1);

      x_next = {1'b0, x} + 1'b1;
      y_next = {1'b0, y} + 1'b1;
      if (x_next >= width_ff) begin
         col_in = '0;
         row_in = (y_next >= height_ff) ? '0 : RW'(y_next);
      end else begin
         col_in = CW'(x_next);
         row_in = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(W_RESET);
         height_ff <= HW'(H_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   assign pos_x               = x;
   assign pos_y               = y;
   assign pos_flags.res_valid = (x != '0) && (y != '0);
   assign pos_flags.inner     = (x >= CW'(2)) && (y >= RW'(2));

endmodule

// ===== rtl/core/smo_window.sv =====
// read-modify-write stage of the line store, 3x3 window and result register
// depends on smo_pkg
`timescale 1ns / 1ps

module smo_window #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_accept,
   input  logic                                in_selected,
   input  logic [$clog2(MAX_WIDTH)-1:0]        in_x,
   input  logic [$clog2(MAX_HEIGHT)-1:0]       in_y,
   input  smo_pkg::pos_flags_type              in_flags,
   output logic                                can_accept,
   input  smo_pkg::line_entry_type             rd_data,
   output logic                                wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]        wr_addr,
   output smo_pkg::line_entry_type             wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_outline,
   output logic [smo_pkg::PIX_W-1:0]           rsp_pixel_x,
   output logic [smo_pkg::PIX_W-1:0]           rsp_pixel_y,
   output logic                                rsp_result_valid
);
   import smo_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic           s1_valid_ff;
   logic [CW-1:0]  s1_x_ff;
   logic [RW-1:0]  s1_y_ff;
   pos_flags_type  s1_flags_ff;
   logic           s1_bit_ff;
   logic           fwd_ff;
   line_entry_type fwd_data_ff;
   logic [8:0]     win_ff;
   logic [8:0]     win_in;
   logic           s1_adv;
   line_entry_type entry;
   line_entry_type new_entry;
   logic           mark;
   logic [CW-1:0]  x_m1;
   logic [RW-1:0]  y_m1;
   logic           rsp_valid_ff;
   logic           rsp_outline_ff;
   logic [PIX_W-1:0] rsp_x_ff;
   logic [PIX_W-1:0] rsp_y_ff;
   logic           rsp_res_valid_ff;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign can_accept = !s1_valid_ff || s1_adv;

   // same entry written by the item ahead at this item's read edge
   assign entry         = fwd_ff ? fwd_data_ff : rd_data;
   assign new_entry.mid = s1_bit_ff;
   assign new_entry.up  = entry.mid;

   assign wr_en   = s1_adv;
   assign wr_addr = s1_x_ff;
   assign wr_data = new_entry;

   assign win_in = {win_ff[5:0], s1_bit_ff, entry.mid, entry.up};
   assign mark   = s1_flags_ff.res_valid && s1_flags_ff.inner && !win_in[CENTRE_BIT]
                   && ((win_in & NEIGHBOUR_MASK) != '0);
   assign x_m1   = s1_x_ff - 1'b1;
   assign y_m1   = s1_y_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         win_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= s1_adv && (s1_x_ff == in_x);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            win_ff       <= win_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_x_ff     <= in_x;
         s1_y_ff     <= in_y;
         s1_flags_ff <= in_flags;
         s1_bit_ff   <= in_selected;
         fwd_data_ff <= new_entry;
      end
      if (s1_adv) begin
         rsp_outline_ff   <= mark;
         rsp_x_ff         <= s1_flags_ff.res_valid ? PIX_W'(x_m1) : '0;
         rsp_y_ff         <= s1_flags_ff.res_valid ? PIX_W'(y_m1) : '0;
         rsp_res_valid_ff <= s1_flags_ff.res_valid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outline      = rsp_outline_ff;
   assign rsp_pixel_x      = rsp_x_ff;
   assign rsp_pixel_y      = rsp_y_ff;
   assign rsp_result_valid = rsp_res_valid_ff;

endmodule

// ===== rtl/core/selection_mask_outline_3x3.sv =====
// outer boundary of a binary mask over a 3x3 neighbourhood, one pixel per item
// an accepted item goes to the window stage register, then the result register; throughput
// 1 item per cycle while results are taken, set by the single read and write port of the
// line store (same entry forwarded); reset: sizes return to 800 x 600, counters and window
// clear; the line store then clears its MAX_WIDTH entries, one a cycle, with req_ready low
// depends on smo_pkg, smo_position, smo_line_mem, smo_window
`timescale 1ns / 1ps

module selection_mask_outline_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  smo_pkg::csr_index_type              csr_index,
   input  logic [smo_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_selected,
   input  logic                                req_frame_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_outline,
   output logic [smo_pkg::PIX_W-1:0]           rsp_pixel_x,
   output logic [smo_pkg::PIX_W-1:0]           rsp_pixel_y,
   output logic                                rsp_result_valid
);
   import smo_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic           accept;
   logic           can_accept;
   logic           mem_busy;
   logic [CW-1:0]  pos_x;
   logic [RW-1:0]  pos_y;
   pos_flags_type  pos_flags;
   line_entry_type rd_data;
   logic           wr_en;
   logic [CW-1:0]  wr_addr;
   line_entry_type wr_data;

   assign req_ready = can_accept && !mem_busy;
   assign accept    = req_valid && req_ready;

   smo_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .frame_start      (req_frame_start),
      .pos_x            (pos_x),
      .pos_y            (pos_y),
      .pos_flags        (pos_flags)
   );

   smo_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (pos_x),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .busy    (mem_busy)
   );

   smo_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window (
      .clock            (clock),
      .reset            (reset),
      .in_accept        (accept),
      .in_selected      (req_selected),
      .in_x             (pos_x),
      .in_y             (pos_y),
      .in_flags         (pos_flags),
      .can_accept       (can_accept),
      .rd_data          (rd_data),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_outline      (rsp_outline),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_result_valid (rsp_result_valid)
   );

endmodule

// ===== sim/smo_outline_checker.sv =====
// checker for selection_mask_outline_3x3: predicts the outline result of every accepted item
// and compares it field by field with the results that leave the block
// depends on smo_pkg
`timescale 1ns / 1ps

module smo_outline_checker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  smo_pkg::csr_index_type         csr_index,
   input  logic [smo_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_selected,
   input  logic                           req_frame_start,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_outline,
   input  logic [smo_pkg::PIX_W-1:0]      rsp_pixel_x,
   input  logic [smo_pkg::PIX_W-1:0]      rsp_pixel_y,
   input  logic                           rsp_result_valid,
   output int                             pending,
   output int                             failures,
   output int                             checked,
   output int                             marks
);
   import smo_pkg::*;

   typedef struct packed {
      logic             outline;
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
      logic             result_valid;
   } outline_result_type;

   outline_result_type    expected_outlines[$];
   bit                    upper_line  [MAX_WIDTH];
   bit                    middle_line [MAX_WIDTH];
   logic [8:0]            window;
   int unsigned           next_col;
   int unsigned           next_row;
   logic [CSR_DATA_W-1:0] width_setting;
   logic [CSR_DATA_W-1:0] height_setting;

   function automatic int unsigned size_in_use(logic [CSR_DATA_W-1:0] value, int unsigned limit);
      if (value < MIN_SIZE) return MIN_SIZE;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic outline_result_type predict_outline(logic sel, logic fs);
      int unsigned        w;
      int unsigned        h;
      int unsigned        x;
      int unsigned        y;
      logic               up;
      logic               mid;
      outline_result_type r;
      w = size_in_use(width_setting, MAX_WIDTH);
      h = size_in_use(height_setting, MAX_HEIGHT);
      if (fs) begin
         next_col = 0;
         next_row = 0;
      end
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (next_row >= h) next_row = 0;
      x = next_col;
      y = next_row;
      up = upper_line[x];
      mid = middle_line[x];
      upper_line[x] = mid;
      middle_line[x] = sel;
      window = {window[5:0], sel, mid, up};
      r = '0;
      if (x >= 1 && y >= 1) begin
         r.result_valid = 1'b1;
         r.pixel_x = PIX_W'(x - 1);
         r.pixel_y = PIX_W'(y - 1);
         // frame edge pixels are never marked
         if (x >= 2 && y >= 2) begin
            r.outline = !window[CENTRE_BIT] && |(window & NEIGHBOUR_MASK);
         end
      end
      next_col = x + 1;
      if (next_col >= w) begin
         next_col = 0;
         next_row = y + 1;
         if (next_row >= h) next_row = 0;
      end
      return r;
   endfunction

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      outline_result_type want;
      if (reset) begin
         expected_outlines.delete();
         foreach (upper_line[i]) begin
            upper_line[i] = 1'b0;
            middle_line[i] = 1'b0;
         end
         window = '0;
         next_col = 0;
         next_row = 0;
         width_setting = RESET_WIDTH;
         height_setting = RESET_HEIGHT;
         failures = 0;
         checked = 0;
         marks = 0;
         pending <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_setting = csr_write_data;
               CSR_FRAME_HEIGHT: height_setting = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_outlines.push_back(predict_outline(req_selected, req_frame_start));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_outlines.size() == 0) begin
               $error("result with no item outstanding: outline %0d x %0d y %0d valid %0d",
                      rsp_outline, rsp_pixel_x, rsp_pixel_y, rsp_result_valid);
               failures++;
            end else begin
               want = expected_outlines.pop_front();
               checked++;
               if (rsp_outline) marks++;
               compare_field("outline", want.outline, rsp_outline);
               compare_field("pixel_x", want.pixel_x, rsp_pixel_x);
               compare_field("pixel_y", want.pixel_y, rsp_pixel_y);
               compare_field("result_valid", want.result_valid, rsp_result_valid);
            end
         end
         pending <= expected_outlines.size();
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// top of the selection_mask_outline_3x3 testbench: clock, reset, size settings and mask
// stimulus with random idling on both channels; verdict from smo_outline_checker
// depends on smo_pkg, selection_mask_outline_3x3, smo_outline_checker
`timescale 1ns / 1ps

module tb_top;
   import smo_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   csr_index_type         csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_selected = 1'b0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_ready = 1'b0;
   logic                  req_ready;
   logic                  rsp_valid;
   logic                  rsp_outline;
   logic [PIX_W-1:0]      rsp_pixel_x;
   logic [PIX_W-1:0]      rsp_pixel_y;
   logic                  rsp_result_valid;
   int                    pending;
   int                    failures;
   int                    checked;
   int                    marks;
   int                    pixels_sent = 0;
   int                    settings_used = 0;
   bit                    steady = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   selection_mask_outline_3x3 DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_selected     (req_selected),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_outline      (rsp_outline),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_result_valid (rsp_result_valid)
   );

   smo_outline_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_selected     (req_selected),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_outline      (rsp_outline),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_result_valid (rsp_result_valid),
      .pending          (pending),
      .failures         (failures),
      .checked          (checked),
      .marks            (marks)
   );

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic send_pixel(logic sel, logic fs);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_selected <= sel;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_sizes(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_write_data <= w;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
      steady = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_frame9(logic [8:0] pattern, logic fs_first);
      for (int i = 0; i < 9; i++) send_pixel(pattern[i], fs_first && i == 0);
   endtask

   // frames of random density; noise is the chance per thousand of a stray frame start
   task automatic run_frames(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h, int area,
                             int count, int noise, bit fresh);
      int   pos;
      int   density;
      logic fs;
      set_sizes(w, h);
      pos = fresh ? 0 : 1;
      density = 50;
      repeat (count) begin
         if (pos == 0) fs = ($urandom_range(0, 4) != 0);
         else fs = ($urandom_range(0, 999) < noise);
         if (fs || pos == 0) begin
            pos = 0;
            case ($urandom_range(0, 3))
               0: density = 3;
               1: density = 25;
               2: density = 50;
               default: density = 92;
            endcase
         end
         send_pixel($urandom_range(0, 99) < density, fs);
         pos = (pos + 1) % area;
      end
      settle();
   endtask

   initial begin : result_side
      int stall;
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_sizes(3, 3);
      send_frame9(9'b111_101_111, 1'b1);
      // next frame follows by wrap alone
      send_frame9(9'b000_000_001, 1'b0);
      // frame start in the middle of a row
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b0, 1'b1);
      send_pixel(1'b1, 1'b0);
      settle();

      run_frames(0, 1, 9, 150, 5, 1'b1);
      run_frames(5, 4, 20, 150, 5, 1'b1);
      run_frames(2047, 2047, 1024 * 1024, 1100, 0, 1'b1);
      // sizes shrink below the current position
      run_frames(5, 2, 15, 150, 5, 1'b0);
      run_frames(3, 1024, 3 * 1024, 150, 0, 1'b1);
      run_frames(16, 8, 128, 150, 5, 1'b0);
      run_frames(7, 9, 63, 100, 5, 1'b1);
      run_frames(2, 1025, 3 * 1024, 50, 0, 1'b0);
      run_frames(800, 600, 800 * 600, 50, 0, 1'b1);

      $display("%0d mask pixels over %0d size settings", pixels_sent, settings_used);
      $display("%0d results checked, %0d outline marks among them", checked, marks);
      if (failures == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/smo_pkg.sv
rtl/core/smo_line_mem.sv
rtl/core/smo_position.sv
rtl/core/smo_window.sv
rtl/core/selection_mask_outline_3x3.sv
sim/smo_outline_checker.sv
sim/tb_top.sv
